>>> hw/rtl/rdq_pkg.sv
// Shared types and constants for the ring deque block.
package rdq_pkg;

   localparam int SLOTS      = 64;
   localparam int DATA_WIDTH = 8;
   localparam int CNT_W      = 6;
   localparam int MAX_COUNT  = 63;
   localparam int KIND_W     = 3;
   localparam int POS_W      = 7;
   localparam int ADDR_W     = 3;
   localparam int CSR_W      = 32;

   localparam logic [CNT_W-1:0] CAP_RESET = 6'd63;

   // Register select: paddr bit ADDR_W-1 picks the 32-bit word.
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_READ       = 3'd4,
      KIND_OVERWRITE  = 3'd5,
      KIND_FIND       = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] target;
   } cell_ctl_type;

endpackage

>>> hw/rtl/ring_deque_indexed.sv
// Top level of the ring deque: handshake, count, capacity register, result register.
//
// Double-ended queue of up to capacity entries (capacity register at byte address 0,
// reset 63, saturated to min(SLOTS-1, MAX_COUNT); writing it empties the deque). Entries
// live in a row of cells ordered by front-relative position, so a push or pop at the front
// shifts the whole row one place and find compares every held entry at once. A transaction
// is registered at acceptance and executed on the cell row once the result register is
// free or being read; the result register then raises rsp_valid. The next request is taken
// in the same cycle one executes, giving one transaction per cycle while rsp_ready is
// high. The limit is the single cell-row update per cycle. No clearing pass after reset.
module ring_deque_indexed #(
   parameter int SLOTS      = rdq_pkg::SLOTS,
   parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rdq_pkg::KIND_W-1:0]        req_kind,
   input  logic [DATA_WIDTH-1:0]             req_data,
   input  logic signed [rdq_pkg::POS_W-1:0]  req_position,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [DATA_WIDTH-1:0]             rsp_value,
   output logic [rdq_pkg::CNT_W-1:0]         rsp_found_position,
   output logic [rdq_pkg::CNT_W-1:0]         rsp_count,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rdq_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [rdq_pkg::CSR_W-1:0]         csr_pwdata,
   output logic [rdq_pkg::CSR_W-1:0]         csr_prdata,
   output logic                              csr_pready
);

   localparam int CW    = rdq_pkg::CNT_W;
   localparam int DEPTH = (SLOTS - 1 < rdq_pkg::MAX_COUNT) ? SLOTS - 1 : rdq_pkg::MAX_COUNT;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // request stage
   logic                             busy_ff;
   rdq_pkg::kind_type                kind_ff;
   logic [DATA_WIDTH-1:0]            data_ff;
   logic signed [rdq_pkg::POS_W-1:0] position_ff;

   // deque state
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] capacity_ff;

   // result stage
   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [CW-1:0]         rsp_found_position_ff;
   logic [CW-1:0]         rsp_count_ff;

   logic                  exec;
   logic                  req_fire;
   logic                  csr_write;
   logic [CW-1:0]         cap_eff;
   logic                  full;
   logic                  empty;
   logic signed [7:0]     pos_ext;
   logic [7:0]            idx_sum;
   logic                  in_range;
   logic [CW-1:0]         idx;

   rdq_pkg::cell_ctl_type ctl;
   logic [CW-1:0]         sel;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  any_hit;
   logic [CW-1:0]         hit_pos;
   logic                  ok;
   logic                  use_rd;
   logic [CW-1:0]         fpos;

   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || exec;
   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign cap_eff = (capacity_ff > DEPTH_C) ? DEPTH_C : capacity_ff;
   assign full    = (count_ff == cap_eff);
   assign empty   = (count_ff == '0);

   // negative positions count back from the entry count
   assign pos_ext  = 8'(position_ff);
   assign idx_sum  = {2'b00, count_ff} + 8'(pos_ext);
   assign in_range = position_ff[rdq_pkg::POS_W-1] ? !idx_sum[7]
                                                   : (position_ff[CW-1:0] < count_ff);
   assign idx      = position_ff[rdq_pkg::POS_W-1] ? idx_sum[CW-1:0] : position_ff[CW-1:0];

   always_comb begin
      ctl.op     = rdq_pkg::CELL_HOLD;
      ctl.target = '0;
      sel        = '0;
      ok         = 1'b0;
      use_rd     = 1'b0;
      fpos       = '0;
      count_in   = count_ff;
      if (exec) begin
         unique case (kind_ff)
            rdq_pkg::KIND_PUSH_FRONT: begin
               if (!full) begin
                  ctl.op   = rdq_pkg::CELL_SHIFT_UP;
                  ok       = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            rdq_pkg::KIND_PUSH_BACK: begin
               if (!full) begin
                  ctl.op     = rdq_pkg::CELL_LOAD;
                  ctl.target = count_ff;
                  ok         = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            rdq_pkg::KIND_POP_FRONT: begin
               if (!empty) begin
                  ctl.op   = rdq_pkg::CELL_SHIFT_DOWN;
                  ok       = 1'b1;
                  use_rd   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            rdq_pkg::KIND_POP_BACK: begin
               sel = count_ff - 1'b1;
               if (!empty) begin
                  ok       = 1'b1;
                  use_rd   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            rdq_pkg::KIND_READ: begin
               sel = idx;
               if (in_range) begin
                  ok     = 1'b1;
                  use_rd = 1'b1;
               end
            end
            rdq_pkg::KIND_OVERWRITE: begin
               if (in_range) begin
                  ctl.op     = rdq_pkg::CELL_LOAD;
                  ctl.target = idx;
                  ok         = 1'b1;
               end
            end
            rdq_pkg::KIND_FIND: begin
               ok   = any_hit;
               fpos = any_hit ? hit_pos : '0;
            end
            rdq_pkg::KIND_CLEAR: begin
               ok       = 1'b1;
               count_in = '0;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
   end

   rdq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .wdata   (data_ff),
      .key     (data_ff),
      .held    (count_ff),
      .sel     (sel),
      .rd_data (rd_data),
      .any_hit (any_hit),
      .hit_pos (hit_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         capacity_ff  <= rdq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (exec) begin
            busy_ff <= 1'b0;
         end
         if (csr_write && csr_paddr[rdq_pkg::ADDR_W-1] == rdq_pkg::REG_CAPACITY) begin
            capacity_ff <= csr_pwdata[CW-1:0];
            count_ff    <= '0;
         end else begin
            count_ff <= count_in;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= rdq_pkg::kind_type'(req_kind);
         data_ff     <= req_data;
         position_ff <= req_position;
      end
      if (exec) begin
         rsp_ok_ff             <= ok;
         rsp_value_ff          <= use_rd ? rd_data : '0;
         rsp_found_position_ff <= fpos;
         rsp_count_ff          <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_count          = rsp_count_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[rdq_pkg::ADDR_W-1] == rdq_pkg::REG_CAPACITY)
                       ? {{(rdq_pkg::CSR_W - CW){1'b0}}, capacity_ff} : '0;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("entry count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_value == '0 && rsp_found_position == '0))
      else $error("failed transaction returned data");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec |=> (rsp_valid && rsp_count == count_ff))
      else $error("executed transaction lost its result");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (exec && !csr_write) |=> (count_ff == $past(count_ff)
                                || count_ff == CW'($past(count_ff) + 1'b1)
                                || count_ff == CW'($past(count_ff) - 1'b1)
                                || count_ff == '0))
      else $error("count moved by more than one entry");
`endif

endmodule

>>> hw/rtl/rdq_cell.sv
// One deque entry: holds the value at a fixed front-relative position.
module rdq_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH
) (
   input  logic                         clock,
   input  rdq_pkg::cell_ctl_type        ctl,
   input  logic [DATA_WIDTH-1:0]        wdata,
   input  logic [DATA_WIDTH-1:0]        from_prev,
   input  logic [DATA_WIDTH-1:0]        from_next,
   input  logic [DATA_WIDTH-1:0]        key,
   input  logic [rdq_pkg::CNT_W-1:0]    held,
   output logic [DATA_WIDTH-1:0]        value,
   output logic                         hit
);

   localparam logic [rdq_pkg::CNT_W-1:0] MY_POS = rdq_pkg::CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      unique case (ctl.op)
         rdq_pkg::CELL_HOLD:       value_in = value_ff;
         rdq_pkg::CELL_SHIFT_UP:   value_in = from_prev;
         rdq_pkg::CELL_SHIFT_DOWN: value_in = from_next;
         rdq_pkg::CELL_LOAD:       value_in = (ctl.target == MY_POS) ? wdata : value_ff;
         default:                  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // only entries inside the current count may match
   assign hit   = (value_ff == key) && (MY_POS < held);

endmodule

>>> hw/rtl/rdq_chain.sv
// Row of deque cells with the read select and first-match encoder.
module rdq_chain #(
   parameter int DEPTH      = rdq_pkg::MAX_COUNT,
   parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH
) (
   input  logic                         clock,
   input  rdq_pkg::cell_ctl_type        ctl,
   input  logic [DATA_WIDTH-1:0]        wdata,
   input  logic [DATA_WIDTH-1:0]        key,
   input  logic [rdq_pkg::CNT_W-1:0]    held,
   input  logic [rdq_pkg::CNT_W-1:0]    sel,
   output logic [DATA_WIDTH-1:0]        rd_data,
   output logic                         any_hit,
   output logic [rdq_pkg::CNT_W-1:0]    hit_pos
);

   logic [DATA_WIDTH-1:0] cell_val [DEPTH];
   logic [DEPTH-1:0]      cell_hit;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_val;
      logic [DATA_WIDTH-1:0] next_val;

      if (g == 0) begin : g_head
         assign prev_val = wdata;
      end else begin : g_mid
         assign prev_val = cell_val[g-1];
      end

      // the last cell keeps its own value on a shift down; it lies outside the count after a pop
      if (g == DEPTH - 1) begin : g_tail
         assign next_val = cell_val[g];
      end else begin : g_body
         assign next_val = cell_val[g+1];
      end

      rdq_cell #(
         .INDEX      (g),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wdata     (wdata),
         .from_prev (prev_val),
         .from_next (next_val),
         .key       (key),
         .held      (held),
         .value     (cell_val[g]),
         .hit       (cell_hit[g])
      );
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel == rdq_pkg::CNT_W'(i)) begin
            rd_data = rd_data | cell_val[i];
         end
      end
   end

   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            hit_pos = rdq_pkg::CNT_W'(i);
         end
      end
   end

   assign any_hit = |cell_hit;

endmodule

>>> bench/ring_deque_indexed_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ring deque: a directed table, then random traffic.
module ring_deque_indexed_tb;

   localparam logic [rdq_pkg::ADDR_W-1:0] CAPACITY_ADDR = '0;
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 45;
   localparam int N_PHASES         = 8;
   localparam int N_ROWS           = 27;
   localparam int PRINT_LIMIT      = 30;
   localparam int JUNK_W           = rdq_pkg::CSR_W - rdq_pkg::CNT_W;

   typedef struct packed {
      logic                           ok;
      logic [rdq_pkg::DATA_WIDTH-1:0] value;
      logic [rdq_pkg::CNT_W-1:0]      found_position;
      logic [rdq_pkg::CNT_W-1:0]      count;
   } deque_result_type;

   typedef struct packed {
      logic                             is_cfg;   // data carries a new capacity, no transaction
      rdq_pkg::kind_type                kind;
      logic [rdq_pkg::DATA_WIDTH-1:0]   data;
      logic signed [rdq_pkg::POS_W-1:0] position;
      logic                             typed;
      deque_result_type                 want;
   } dir_row_type;

   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_ready;
   logic [rdq_pkg::KIND_W-1:0]       req_kind     = '0;
   logic [rdq_pkg::DATA_WIDTH-1:0]   req_data     = '0;
   logic signed [rdq_pkg::POS_W-1:0] req_position = '0;
   logic                             rsp_valid;
   logic                             rsp_ready    = 1'b0;
   logic                             rsp_ok;
   logic [rdq_pkg::DATA_WIDTH-1:0]   rsp_value;
   logic [rdq_pkg::CNT_W-1:0]        rsp_found_position;
   logic [rdq_pkg::CNT_W-1:0]        rsp_count;
   logic                             csr_psel     = 1'b0;
   logic                             csr_penable  = 1'b0;
   logic                             csr_pwrite   = 1'b0;
   logic [rdq_pkg::ADDR_W-1:0]       csr_paddr    = '0;
   logic [rdq_pkg::CSR_W-1:0]        csr_pwdata   = '0;
   logic [rdq_pkg::CSR_W-1:0]        csr_prdata;
   logic                             csr_pready;

   // predictor state: front of the deque is index 0
   logic [rdq_pkg::DATA_WIDTH-1:0] deque_q [$];
   int                             cap_limit = 63;
   deque_result_type               pending_results [$];

   dir_row_type dir_rows [N_ROWS];
   int phase_caps [N_PHASES] = '{63, 1, 2, 7, 63, 0, 32, 63};   // 0: pick at random

   int idle_pct  = 0;
   int stall_pct = 0;
   int errors    = 0;
   int quiet_cycles = 0;
   int items_sent = 0, results_checked = 0, cap_writes = 0;
   int full_refusals = 0, empty_pops = 0, bad_positions = 0, find_hits = 0;

   ring_deque_indexed DUT (.*);

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   function automatic deque_result_type plain_result(input logic ok, input int cnt);
      deque_result_type r;
      r = '0;
      r.ok = ok;
      r.count = rdq_pkg::CNT_W'(cnt);
      return r;
   endfunction

   function automatic deque_result_type predict_deque(
         input rdq_pkg::kind_type k,
         input logic [rdq_pkg::DATA_WIDTH-1:0] d,
         input logic signed [rdq_pkg::POS_W-1:0] p);
      deque_result_type r;
      int n, idx;
      r = '0;
      n = deque_q.size();
      unique case (k)
         rdq_pkg::KIND_PUSH_FRONT, rdq_pkg::KIND_PUSH_BACK: begin
            if (n < cap_limit) begin
               if (k == rdq_pkg::KIND_PUSH_FRONT) deque_q.push_front(d);
               else deque_q.push_back(d);
               r.ok = 1'b1;
            end else begin
               full_refusals++;
            end
         end
         rdq_pkg::KIND_POP_FRONT, rdq_pkg::KIND_POP_BACK: begin
            if (n != 0) begin
               r.value = (k == rdq_pkg::KIND_POP_FRONT) ? deque_q.pop_front()
                                                        : deque_q.pop_back();
               r.ok = 1'b1;
            end else begin
               empty_pops++;
            end
         end
         rdq_pkg::KIND_READ, rdq_pkg::KIND_OVERWRITE: begin
            // negative positions count back from the end: -1 is the back entry
            idx = (p >= 0) ? int'(p) : n + int'(p);
            if (idx >= 0 && idx < n) begin
               if (k == rdq_pkg::KIND_READ) r.value = deque_q[idx];
               else deque_q[idx] = d;
               r.ok = 1'b1;
            end else begin
               bad_positions++;
            end
         end
         rdq_pkg::KIND_FIND: begin
            for (int i = 0; i < n; i++) begin
               if (!r.ok && deque_q[i] == d) begin
                  r.ok = 1'b1;
                  r.found_position = rdq_pkg::CNT_W'(i);
               end
            end
            if (r.ok) find_hits++;
         end
         default: begin
            deque_q.delete();
            r.ok = 1'b1;
         end
      endcase
      r.count = rdq_pkg::CNT_W'(deque_q.size());
      return r;
   endfunction

   task automatic send_item(input rdq_pkg::kind_type k,
                            input logic [rdq_pkg::DATA_WIDTH-1:0] d,
                            input logic signed [rdq_pkg::POS_W-1:0] p, input logic typed,
                            input deque_result_type want);
      deque_result_type got;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= k;
      req_data     <= d;
      req_position <= p;
      do @(posedge clock); while (!req_ready);
      got = predict_deque(k, d, p);
      pending_results.push_back(typed ? want : got);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // only called with the block idle; a capacity write also empties the deque
   task automatic write_capacity(input logic [rdq_pkg::CNT_W-1:0] cap,
                                 input logic [JUNK_W-1:0] junk);
      drain_results();
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CAPACITY_ADDR;
      csr_pwdata <= {junk, cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      deque_q.delete();
      cap_limit = int'(cap);
      cap_writes++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== rdq_pkg::CSR_W'(cap))
         report_mismatch("capacity readback", csr_prdata, 32'(cap));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side: check each accepted transaction, then pick next cycle's ready
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_count), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", 32'(rsp_ok), 32'(want.ok));
            if (rsp_value !== want.value)
               report_mismatch("value", 32'(rsp_value), 32'(want.value));
            if (rsp_found_position !== want.found_position)
               report_mismatch("found_position", 32'(rsp_found_position),
                               32'(want.found_position));
            if (rsp_count !== want.count)
               report_mismatch("count", 32'(rsp_count), 32'(want.count));
            results_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int cap, n, roll, streak_left;
      bit filling;
      rdq_pkg::kind_type k;
      logic [rdq_pkg::DATA_WIDTH-1:0] d;
      logic signed [rdq_pkg::POS_W-1:0] p;

      dir_rows = '{
         // reset state: empty deque, capacity 63
         '{1'b0, rdq_pkg::KIND_POP_FRONT, 8'h00, 7'sd0, 1'b1, plain_result(1'b0, 0)},
         '{1'b0, rdq_pkg::KIND_POP_BACK, 8'h00, 7'sd0, 1'b1, plain_result(1'b0, 0)},
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, 7'sd0, 1'b1, plain_result(1'b0, 0)},
         '{1'b0, rdq_pkg::KIND_FIND, 8'h00, 7'sd0, 1'b1, plain_result(1'b0, 0)},
         '{1'b0, rdq_pkg::KIND_CLEAR, 8'h00, 7'sd0, 1'b1, plain_result(1'b1, 0)},
         '{1'b1, rdq_pkg::KIND_CLEAR, 8'd2, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_PUSH_BACK, 8'hFF, 7'sd0, 1'b1, plain_result(1'b1, 1)},
         '{1'b0, rdq_pkg::KIND_PUSH_FRONT, 8'h00, 7'sd0, 1'b1, plain_result(1'b1, 2)},
         // full: both pushes refused
         '{1'b0, rdq_pkg::KIND_PUSH_BACK, 8'h55, 7'sd0, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_PUSH_FRONT, 8'hAA, 7'sd0, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, -7'sd1, 1'b0, '0},
         // positions just past either end, and the field extremes
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, 7'sd2, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, -7'sd3, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, 7'h40, 1'b1, plain_result(1'b0, 2)},   // -64
         '{1'b0, rdq_pkg::KIND_READ, 8'h00, 7'sd63, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_OVERWRITE, 8'hA5, -7'sd2, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_OVERWRITE, 8'hA5, 7'sd5, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_FIND, 8'hFF, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_FIND, 8'h12, 7'sd0, 1'b1, plain_result(1'b0, 2)},
         '{1'b0, rdq_pkg::KIND_POP_BACK, 8'h00, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_POP_FRONT, 8'h00, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_OVERWRITE, 8'h7F, 7'sd0, 1'b1, plain_result(1'b0, 0)},
         '{1'b1, rdq_pkg::KIND_CLEAR, 8'd1, 7'sd0, 1'b0, '0},
         '{1'b0, rdq_pkg::KIND_PUSH_FRONT, 8'h80, 7'sd0, 1'b1, plain_result(1'b1, 1)},
         '{1'b0, rdq_pkg::KIND_PUSH_BACK, 8'h01, 7'sd0, 1'b1, plain_result(1'b0, 1)},
         '{1'b0, rdq_pkg::KIND_CLEAR, 8'h00, 7'sd0, 1'b1, plain_result(1'b1, 0)}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            write_capacity(dir_rows[i].data[rdq_pkg::CNT_W-1:0], '0);
         else
            send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].position,
                      dir_rows[i].typed, dir_rows[i].want);
      end

      filling = 1'b1;
      streak_left = 20;
      for (int phase = 0; phase < N_PHASES; phase++) begin
         cap = (phase_caps[phase] == 0) ? $urandom_range(1, 63) : phase_caps[phase];
         write_capacity(rdq_pkg::CNT_W'(cap), JUNK_W'($urandom));
         idle_pct  = (phase % 4 == 1) ? 45 : (phase % 4 == 3) ? 34 : 0;
         stall_pct = (phase % 4 == 2) ? 45 : (phase % 4 == 3) ? 34 : 0;

         // fill to the brim and push twice more, each push at a random end, so refusals are seen
         for (int i = 0; i < cap + 2; i++)
            send_item($urandom_range(1) ? rdq_pkg::KIND_PUSH_BACK : rdq_pkg::KIND_PUSH_FRONT,
                      rdq_pkg::DATA_WIDTH'($urandom_range(255)),
                      rdq_pkg::POS_W'($urandom_range(127)), 1'b0, '0);

         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (phase % 2 == 1 && i == RANDOM_PER_PHASE / 2) drain_results();
            if (--streak_left <= 0) begin
               filling = !filling;
               streak_left = $urandom_range(8, 30);
            end
            n = deque_q.size();
            d = rdq_pkg::DATA_WIDTH'(($urandom_range(3) == 0) ? $urandom_range(3)
                                                               : $urandom_range(255));
            p = rdq_pkg::POS_W'($urandom_range(127));
            if ($urandom_range(99) < 10) begin
               k = rdq_pkg::kind_type'($urandom_range(7));
            end else begin
               roll = $urandom_range(99);
               if (roll < 50) begin
                  if (roll < (filling ? 40 : 10))
                     k = $urandom_range(1) ? rdq_pkg::KIND_PUSH_BACK
                                           : rdq_pkg::KIND_PUSH_FRONT;
                  else
                     k = $urandom_range(1) ? rdq_pkg::KIND_POP_BACK
                                           : rdq_pkg::KIND_POP_FRONT;
               end else if (roll < 65) begin
                  k = rdq_pkg::KIND_READ;
               end else if (roll < 77) begin
                  k = rdq_pkg::KIND_OVERWRITE;
               end else if (roll < 97) begin
                  k = rdq_pkg::KIND_FIND;
               end else begin
                  k = rdq_pkg::KIND_CLEAR;
               end
               if (n > 0 && $urandom_range(9) < 8)
                  p = rdq_pkg::POS_W'($urandom_range(1) ? $urandom_range(n - 1)
                                                        : -$urandom_range(1, n));
               else
                  p = rdq_pkg::POS_W'($urandom_range(1) ? n : -(n + 1));
               if (k == rdq_pkg::KIND_FIND && n > 0 && $urandom_range(9) < 6)
                  d = deque_q[$urandom_range(n - 1)];
            end
            send_item(k, d, p, 1'b0, '0);
         end
      end

      drain_results();
      repeat (5) @(posedge clock);
      $display("Ran %0d transactions and %0d capacity writes; %0d results checked.",
               items_sent, cap_writes, results_checked);
      $display("Seen: %0d pushes on full, %0d pops on empty, %0d bad positions, %0d find hits.",
               full_refusals, empty_pops, bad_positions, find_hits);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
